// ===== design/fpc_pkg.sv =====
// Package: shared widths, posture codes, register indexes
`timescale 1ns / 1ps
package fpc_pkg;
    localparam int COORD_BITS_DEF = 12;
    localparam int MOVE_BITS      = 26;
    localparam int SLOPE_BITS     = 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 26;
    localparam int POSTURE_BITS   = 3;
    localparam int NUM_LANES      = 3;
    localparam logic [MOVE_BITS-1:0]  MOVE_RESET  = 26'd24000;
    localparam logic [SLOPE_BITS-1:0] SLOPE_RESET = 8'd3;

    typedef enum logic [POSTURE_BITS-1:0] {
        P_NORMAL = 3'd0, P_NEAR = 3'd1, P_FAR = 3'd2, P_LEFT = 3'd3,
        P_RIGHT = 3'd4, P_UP = 3'd5, P_DOWN = 3'd6
    } t_posture;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        R_LEX = 3'd0, R_LEY = 3'd1, R_REX = 3'd2, R_REY = 3'd3,
        R_MX = 3'd4, R_MY = 3'd5, R_MOVE = 3'd6, R_SLOPE = 3'd7
    } t_cfg_idx;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic ref_zero;
        logic near_ok;
        logic far_ok;
        logic dx_zero;
        logic dx_pos;
        logic dy_pos;
    } t_lane_flags;
endpackage

// ===== design/fpc_if.sv =====
// Interfaces: valid/ready channels for landmarks and posture
`timescale 1ns / 1ps
interface fpc_in_if import fpc_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
    logic valid;
    logic ready;
    logic [COORD_BITS-1:0] left_eye_x, left_eye_y, right_eye_x, right_eye_y;
    logic [COORD_BITS-1:0] mouth_x, mouth_y;
    modport source (output valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
                    mouth_x, mouth_y, input ready);
    modport sink (input valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
                  mouth_x, mouth_y, output ready);
endinterface

interface fpc_out_if import fpc_pkg::*;;
    logic valid;
    logic ready;
    logic [POSTURE_BITS-1:0] posture;
    modport source (output valid, posture, input ready);
    modport sink (input valid, posture, output ready);
endinterface

// ===== design/fpc_div.sv =====
// Divider: restoring unsigned divide, one quotient bit per stage, fully pipelined
`timescale 1ns / 1ps
module fpc_div import fpc_pkg::*; #(
    parameter int W = COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_quo
);
    logic [W-1:0] r_rem [1:W-1];
    logic [W-1:0] r_num [1:W-1];
    logic [W-1:0] r_den [1:W-1];
    logic [W-1:0] r_quo [1:W];

    // stage k produces quotient bit W-1-k
    for (genvar k = 0; k < W; k++) begin : g_st
        logic [W-1:0] w_rem, w_num, w_den, w_quo;
        logic [W:0] n_trial;
        logic [W:0] n_diff;

        if (k == 0) begin : g_in
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_pipe
            assign w_rem = r_rem[k];
            assign w_num = r_num[k];
            assign w_den = r_den[k];
            assign w_quo = r_quo[k];
        end

        assign n_trial = {w_rem, w_num[W-1-k]};
        assign n_diff  = n_trial - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!n_diff[W]) r_quo[k+1] <= w_quo | (W'(1) << (W-1-k));
                else            r_quo[k+1] <= w_quo;
            end
        end

        // operands and partial remainder move on, except after the last stage
        if (k < W-1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k+1] <= w_num;
                    r_den[k+1] <= w_den;
                    if (!n_diff[W]) r_rem[k+1] <= n_diff[W-1:0];
                    else            r_rem[k+1] <= n_trial[W-1:0];
                end
            end
        end
    end

    assign o_quo = r_quo[W];
endmodule

// ===== design/fpc_lane.sv =====
// Lane: one landmark's ratio tests, displacement and slope quotient
`timescale 1ns / 1ps
module fpc_lane import fpc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    // this lane's pair is (a, b); displacement uses live a vs ref a
    input  logic [COORD_BITS-1:0] i_ax, i_ay, i_bx, i_by,
    input  logic [COORD_BITS-1:0] i_rax, i_ray, i_rbx, i_rby,
    output t_lane_flags           o_flags,
    output logic [2*COORD_BITS:0] o_move,
    output logic [COORD_BITS-1:0] o_quo
);
    localparam int CB = COORD_BITS;
    localparam int SQ = 2*CB + 1;
    localparam int RW = SQ + 3;
    localparam int DLY = CB - 1;

    logic [CB:0] n_ldx, n_ldy, n_rdx, n_rdy, n_mdx, n_mdy;
    logic [CB-1:0] n_aldx, n_aldy, n_ardx, n_ardy, n_amdx, n_amdy;
    logic [CB-1:0] r_aldx, r_aldy, r_ardx, r_ardy, r_amdx, r_amdy;
    logic r_dx_zero, r_dx_pos, r_dy_pos;
    logic [SQ-1:0] r_live, r_ref, r_move;
    logic [RW-1:0] n_l5, n_r6, n_r4;
    t_lane_flags r_f [DLY];
    logic [SQ-1:0] r_mv [DLY];
    t_lane_flags n_f;
    logic r_dxz_d, r_dxp_d, r_dyp_d;

    assign n_ldx = {1'b0, i_ax} - {1'b0, i_bx};
    assign n_ldy = {1'b0, i_ay} - {1'b0, i_by};
    assign n_rdx = {1'b0, i_rax} - {1'b0, i_rbx};
    assign n_rdy = {1'b0, i_ray} - {1'b0, i_rby};
    assign n_mdx = {1'b0, i_ax} - {1'b0, i_rax};
    assign n_mdy = {1'b0, i_ay} - {1'b0, i_ray};
    assign n_aldx = n_ldx[CB] ? CB'(-n_ldx) : n_ldx[CB-1:0];
    assign n_aldy = n_ldy[CB] ? CB'(-n_ldy) : n_ldy[CB-1:0];
    assign n_ardx = n_rdx[CB] ? CB'(-n_rdx) : n_rdx[CB-1:0];
    assign n_ardy = n_rdy[CB] ? CB'(-n_rdy) : n_rdy[CB-1:0];
    assign n_amdx = n_mdx[CB] ? CB'(-n_mdx) : n_mdx[CB-1:0];
    assign n_amdy = n_mdy[CB] ? CB'(-n_mdy) : n_mdy[CB-1:0];

    // stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aldx <= n_aldx; r_aldy <= n_aldy;
            r_ardx <= n_ardx; r_ardy <= n_ardy;
            r_amdx <= n_amdx; r_amdy <= n_amdy;
            r_dx_zero <= (n_mdx == '0);
            r_dx_pos  <= !n_mdx[CB] && (n_mdx != '0);
            r_dy_pos  <= !n_mdy[CB] && (n_mdy != '0);
        end
    end

    // stage 2: squared distances (two narrow multiplies each)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_live <= SQ'(r_aldx * r_aldx) + SQ'(r_aldy * r_aldy);
            r_ref  <= SQ'(r_ardx * r_ardx) + SQ'(r_ardy * r_ardy);
            r_move <= SQ'(r_amdx * r_amdx) + SQ'(r_amdy * r_amdy);
        end
    end

    // exact ratio compares: 5*live vs 6*ref / 4*ref
    assign n_l5 = RW'(r_live) + (RW'(r_live) << 2);
    assign n_r6 = (RW'(r_ref) << 2) + (RW'(r_ref) << 1);
    assign n_r4 = RW'(r_ref) << 2;

    // flags for the stage-2 item, delayed below to meet the div result
    assign n_f.ref_zero = (r_ref == '0);
    assign n_f.near_ok  = n_l5 > n_r6;
    assign n_f.far_ok   = n_l5 < n_r4;
    assign n_f.dx_zero  = r_dxz_d;
    assign n_f.dx_pos   = r_dxp_d;
    assign n_f.dy_pos   = r_dyp_d;

    // stage-2 copy of the sign flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dxz_d <= r_dx_zero;
            r_dxp_d <= r_dx_pos;
            r_dyp_d <= r_dy_pos;
        end
    end

    // delay line aligns flags with the divider output
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0]  <= n_f;
            r_mv[0] <= r_move;
            for (int k = 1; k < DLY; k++) begin
                r_f[k]  <= r_f[k-1];
                r_mv[k] <= r_mv[k-1];
            end
        end
    end

    // divider starts from stage-1 values
    fpc_div #(.W(CB)) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_amdy),
        .i_den (r_amdx),
        .o_quo (o_quo)
    );

    assign o_flags = r_f[DLY-1];
    assign o_move  = r_mv[DLY-1];
endmodule

// ===== design/fpc_merge.sv =====
// Merge: combine lane findings into one posture
`timescale 1ns / 1ps
module fpc_merge import fpc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  t_lane_flags           i_flags [NUM_LANES],
    input  logic [2*COORD_BITS:0] i_move  [NUM_LANES],
    input  logic [COORD_BITS-1:0] i_quo   [NUM_LANES],
    input  logic [MOVE_BITS-1:0]  i_move_thr,
    input  logic [SLOPE_BITS-1:0] i_slope_thr,
    output t_posture              o_posture
);
    localparam int MW = 2*COORD_BITS + 3;
    localparam int SW = COORD_BITS + 2;
    // compare width covers both the movement sum and the threshold
    localparam int CW = ((MW > MOVE_BITS) ? MW : MOVE_BITS) + 1;
    logic [MW-1:0] n_move;
    logic [SW-1:0] n_slope;
    logic n_rz, n_near, n_far, n_dxz, n_dxp, n_dyp;

    always_comb begin
        n_move  = MW'(i_move[0]) + MW'(i_move[1]) + MW'(i_move[2]);
        n_slope = SW'(i_quo[0]) + SW'(i_quo[1]) + SW'(i_quo[2]);
        n_rz  = i_flags[0].ref_zero | i_flags[1].ref_zero | i_flags[2].ref_zero;
        n_near = i_flags[0].near_ok & i_flags[1].near_ok & i_flags[2].near_ok;
        n_far  = i_flags[0].far_ok & i_flags[1].far_ok & i_flags[2].far_ok;
        n_dxz = i_flags[0].dx_zero | i_flags[1].dx_zero | i_flags[2].dx_zero;
        n_dxp = i_flags[0].dx_pos & i_flags[1].dx_pos & i_flags[2].dx_pos;
        n_dyp = i_flags[0].dy_pos & i_flags[1].dy_pos & i_flags[2].dy_pos;
        if (n_rz)        o_posture = P_NORMAL;
        else if (n_near) o_posture = P_NEAR;
        else if (n_far)  o_posture = P_FAR;
        else             o_posture = P_NORMAL;
        if (CW'(n_move) > CW'(i_move_thr)) begin
            if (n_dxz) o_posture = P_NORMAL;
            else if ((SW+1)'(n_slope) > (SW+1)'(i_slope_thr))
                o_posture = n_dyp ? P_DOWN : P_UP;
            else
                o_posture = n_dxp ? P_LEFT : P_RIGHT;
        end
    end
endmodule

// ===== design/face_pose_classifier_core.sv =====
// Top level: face posture classifier with three parallel landmark lanes
//  channel  | dir | handshake   | payload
//  in_ch    | in  | valid/ready | six landmark coordinates
//  out_ch   | out | valid/ready | posture code
//  cfg      | in  | write en    | index, data
// Each item passes the lane stages, where the flag delay line keeps pace with the pipelined
// slope divider, then the combinational merge and the output register.
// One item enters per cycle; the whole pipe advances only when the output
// register is free or being taken, so a stall freezes every stage in place.
// Reset is synchronous, clears the valid chain and loads register defaults.
`timescale 1ns / 1ps
module face_pose_classifier_core import fpc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    fpc_in_if.sink                   in_ch,
    fpc_out_if.source                out_ch,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int LAT = COORD_BITS + 1;

    logic [COORD_BITS-1:0] r_rlx, r_rly, r_rrx, r_rry, r_rmx, r_rmy;
    logic [MOVE_BITS-1:0]  r_move_thr;
    logic [SLOPE_BITS-1:0] r_slope_thr;
    logic [LAT-1:0] r_vld;
    logic           r_out_vld;
    t_posture       r_out_pos;
    logic           n_adv;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rlx <= '0; r_rly <= '0; r_rrx <= '0;
            r_rry <= '0; r_rmx <= '0; r_rmy <= '0;
            r_move_thr <= MOVE_RESET; r_slope_thr <= SLOPE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                R_LEX:   r_rlx <= i_cfg_data[COORD_BITS-1:0];
                R_LEY:   r_rly <= i_cfg_data[COORD_BITS-1:0];
                R_REX:   r_rrx <= i_cfg_data[COORD_BITS-1:0];
                R_REY:   r_rry <= i_cfg_data[COORD_BITS-1:0];
                R_MX:    r_rmx <= i_cfg_data[COORD_BITS-1:0];
                R_MY:    r_rmy <= i_cfg_data[COORD_BITS-1:0];
                R_MOVE:  r_move_thr <= i_cfg_data[MOVE_BITS-1:0];
                R_SLOPE: r_slope_thr <= i_cfg_data[SLOPE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipe advances when output slot is empty or taken
    assign n_adv = !r_out_vld || out_ch.ready;
    assign in_ch.ready = n_adv;

    // lanes: left-right / left eye, right-mouth / right eye, mouth-left / mouth
    t_lane_flags           w_flags [NUM_LANES];
    logic [2*COORD_BITS:0] w_move  [NUM_LANES];
    logic [COORD_BITS-1:0] w_quo   [NUM_LANES];
    t_posture              w_pos;

    fpc_lane #(.COORD_BITS(COORD_BITS)) u_lane0 (
        .i_clk(i_clk), .i_en(n_adv),
        .i_ax(in_ch.left_eye_x), .i_ay(in_ch.left_eye_y),
        .i_bx(in_ch.right_eye_x), .i_by(in_ch.right_eye_y),
        .i_rax(r_rlx), .i_ray(r_rly), .i_rbx(r_rrx), .i_rby(r_rry),
        .o_flags(w_flags[0]), .o_move(w_move[0]), .o_quo(w_quo[0]));
    fpc_lane #(.COORD_BITS(COORD_BITS)) u_lane1 (
        .i_clk(i_clk), .i_en(n_adv),
        .i_ax(in_ch.right_eye_x), .i_ay(in_ch.right_eye_y),
        .i_bx(in_ch.mouth_x), .i_by(in_ch.mouth_y),
        .i_rax(r_rrx), .i_ray(r_rry), .i_rbx(r_rmx), .i_rby(r_rmy),
        .o_flags(w_flags[1]), .o_move(w_move[1]), .o_quo(w_quo[1]));
    fpc_lane #(.COORD_BITS(COORD_BITS)) u_lane2 (
        .i_clk(i_clk), .i_en(n_adv),
        .i_ax(in_ch.mouth_x), .i_ay(in_ch.mouth_y),
        .i_bx(in_ch.left_eye_x), .i_by(in_ch.left_eye_y),
        .i_rax(r_rmx), .i_ray(r_rmy), .i_rbx(r_rlx), .i_rby(r_rly),
        .o_flags(w_flags[2]), .o_move(w_move[2]), .o_quo(w_quo[2]));

    fpc_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .i_flags(w_flags), .i_move(w_move), .i_quo(w_quo),
        .i_move_thr(r_move_thr), .i_slope_thr(r_slope_thr),
        .o_posture(w_pos));

    // valid chain and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (n_adv) begin
            r_vld     <= {r_vld[LAT-2:0], in_ch.valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) r_out_pos <= w_pos;
    end

    assign out_ch.valid   = r_out_vld;
    assign out_ch.posture = r_out_pos;
endmodule

// ===== dv/face_pose_classifier_core_checker.sv =====
// Checker: watches the landmark and posture channels, predicts posture, compares
`timescale 1ns / 1ps
module face_pose_classifier_core_checker import fpc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    fpc_in_if.sink                   in_ch,
    fpc_out_if.sink                  out_ch,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_taken,
    output int                       o_delivered
);
    // shadow copy of the reference landmarks and thresholds
    logic [COORD_BITS-1:0] ref_pt [6];
    logic [MOVE_BITS-1:0]  move_thr;
    logic [SLOPE_BITS-1:0] slope_thr;
    t_posture posture_q [$];

    // squared distance between two points, full width
    function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx,
                                                longint by);
        return longint'((ax - bx) * (ax - bx) + (ay - by) * (ay - by));
    endfunction

    // classify one landmark set against the current references
    function automatic t_posture classify(longint lv [6]);
        longint rf [6];
        longint unsigned rd [3], ld [3], moved, slope;
        longint dx [3], dy [3];
        bit near_all, far_all, dx_zero, dx_pos_all, dy_pos_all;
        t_posture p;
        for (int k = 0; k < 6; k++) rf[k] = ref_pt[k];
        rd[0] = sq_dist(rf[0], rf[1], rf[2], rf[3]);
        rd[1] = sq_dist(rf[0], rf[1], rf[4], rf[5]);
        rd[2] = sq_dist(rf[2], rf[3], rf[4], rf[5]);
        ld[0] = sq_dist(lv[0], lv[1], lv[2], lv[3]);
        ld[1] = sq_dist(lv[0], lv[1], lv[4], lv[5]);
        ld[2] = sq_dist(lv[2], lv[3], lv[4], lv[5]);
        near_all = 1; far_all = 1;
        for (int k = 0; k < 3; k++) begin
            if (!(5 * ld[k] > 6 * rd[k])) near_all = 0;
            if (!(5 * ld[k] < 4 * rd[k])) far_all = 0;
        end
        p = P_NORMAL;
        if (rd[0] == 0 || rd[1] == 0 || rd[2] == 0) p = P_NORMAL;
        else if (near_all) p = P_NEAR;
        else if (far_all) p = P_FAR;
        moved = 0; slope = 0; dx_zero = 0; dx_pos_all = 1; dy_pos_all = 1;
        for (int k = 0; k < 3; k++) begin
            dx[k] = lv[2*k] - rf[2*k];
            dy[k] = lv[2*k+1] - rf[2*k+1];
            moved += longint'(dx[k] * dx[k] + dy[k] * dy[k]);
            if (dx[k] == 0) dx_zero = 1;
            if (dx[k] <= 0) dx_pos_all = 0;
            if (dy[k] <= 0) dy_pos_all = 0;
        end
        if (moved > move_thr) begin
            if (dx_zero) p = P_NORMAL;
            else begin
                for (int k = 0; k < 3; k++)
                    slope += longint'((dy[k] < 0 ? -dy[k] : dy[k])
                                      / (dx[k] < 0 ? -dx[k] : dx[k]));
                if (slope > slope_thr) p = dy_pos_all ? P_DOWN : P_UP;
                else p = dx_pos_all ? P_LEFT : P_RIGHT;
            end
        end
        return p;
    endfunction

    // register writes, predictions and comparisons at the rising edge
    always @(posedge i_clk) begin
        longint lv [6];
        t_posture want;
        if (!i_rst_n) begin
            foreach (ref_pt[k]) ref_pt[k] <= '0;
            move_thr <= MOVE_RESET;
            slope_thr <= SLOPE_RESET;
            posture_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
            o_taken <= 0;
            o_delivered <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                lv[0] = in_ch.left_eye_x;  lv[1] = in_ch.left_eye_y;
                lv[2] = in_ch.right_eye_x; lv[3] = in_ch.right_eye_y;
                lv[4] = in_ch.mouth_x;     lv[5] = in_ch.mouth_y;
                posture_q.push_back(classify(lv));
                o_taken <= o_taken + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                o_delivered <= o_delivered + 1;
                if (posture_q.size() == 0) begin
                    $display("%0t: unexpected posture transaction, expected none, actual %0d",
                             $time, out_ch.posture);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = posture_q.pop_front();
                    if (out_ch.posture !== want) begin
                        $display("%0t: posture mismatch, expected %0d, actual %0d",
                                 $time, want, out_ch.posture);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= posture_q.size();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    R_LEX:   ref_pt[0] <= i_cfg_data[COORD_BITS-1:0];
                    R_LEY:   ref_pt[1] <= i_cfg_data[COORD_BITS-1:0];
                    R_REX:   ref_pt[2] <= i_cfg_data[COORD_BITS-1:0];
                    R_REY:   ref_pt[3] <= i_cfg_data[COORD_BITS-1:0];
                    R_MX:    ref_pt[4] <= i_cfg_data[COORD_BITS-1:0];
                    R_MY:    ref_pt[5] <= i_cfg_data[COORD_BITS-1:0];
                    R_MOVE:  move_thr  <= i_cfg_data[MOVE_BITS-1:0];
                    R_SLOPE: slope_thr <= i_cfg_data[SLOPE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/face_pose_classifier_core_tb.sv =====
// Testbench top: clock, reset, landmark stimulus, register phases, verdict
`timescale 1ns / 1ps
module face_pose_classifier_core_tb import fpc_pkg::*;;
    localparam int CB = COORD_BITS_DEF;
    localparam int LATENCY = CB + 2;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    int fail_count, pending, taken, delivered;
    int idle_cycles;
    bit quiet_phase;
    int hold_off;
    int directed_cnt, random_cnt;

    fpc_in_if #(.COORD_BITS(CB)) in_ch ();
    fpc_out_if out_ch ();

    face_pose_classifier_core #(.COORD_BITS(CB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    face_pose_classifier_core_checker #(.COORD_BITS(CB)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_taken(taken),
        .o_delivered(delivered)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // posture sink: random stalls, long hold-off when requested, none in quiet phase
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                out_ch.ready <= 0;
                hold_off = hold_off - 1;
            end else begin
                out_ch.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 8);
            end
        end
    end

    // watchdog on cycles with no transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // one register write at a falling edge
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic write_refs(logic [CB-1:0] lx, ly, rx, ry, mx, my);
        write_reg(R_LEX, lx); write_reg(R_LEY, ly);
        write_reg(R_REX, rx); write_reg(R_REY, ry);
        write_reg(R_MX, mx);  write_reg(R_MY, my);
    endtask

    // offer one landmark set, hold until taken, with optional leading gap
    task automatic send_landmarks(logic [CB-1:0] lx, ly, rx, ry, mx, my);
        while (!quiet_phase && $urandom_range(99) < 8) begin
            @(negedge i_clk);
            in_ch.valid <= 0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1;
        in_ch.left_eye_x <= lx;  in_ch.left_eye_y <= ly;
        in_ch.right_eye_x <= rx; in_ch.right_eye_y <= ry;
        in_ch.mouth_x <= mx;     in_ch.mouth_y <= my;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_ch.valid <= 0;
    endtask

    // wait until every posture is back, then let the pipe drain
    task automatic drain();
        drop_valid();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // point near a reference, offset within +-span, clamped to the coordinate range
    function automatic logic [CB-1:0] near_pt(int base, int span);
        int v;
        v = base + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > int'(CMAX)) v = int'(CMAX);
        return CB'(v);
    endfunction

    // randomized landmark set: mostly scaled or shifted versions of the reference
    task automatic send_random(logic [CB-1:0] r [6]);
        logic [CB-1:0] p [6];
        int kind, cx, cy, sx, sy, num;
        kind = $urandom_range(9);
        if (kind < 2) begin
            for (int k = 0; k < 6; k++) p[k] = CB'($urandom);
        end else if (kind < 5) begin
            // scale about the centroid
            cx = (int'(r[0]) + r[2] + r[4]) / 3;
            cy = (int'(r[1]) + r[3] + r[5]) / 3;
            num = $urandom_range(60, 150);
            for (int k = 0; k < 3; k++) begin
                p[2*k]   = near_pt(cx + (int'(r[2*k]) - cx) * num / 100, 1);
                p[2*k+1] = near_pt(cy + (int'(r[2*k+1]) - cy) * num / 100, 1);
            end
        end else begin
            // common shift, dominant either way, with jitter
            sx = $urandom_range(1) ? $urandom_range(300) - 150 : $urandom_range(20) - 10;
            sy = $urandom_range(1) ? $urandom_range(300) - 150 : $urandom_range(20) - 10;
            for (int k = 0; k < 3; k++) begin
                p[2*k]   = near_pt(int'(r[2*k]) + sx, $urandom_range(2));
                p[2*k+1] = near_pt(int'(r[2*k+1]) + sy, $urandom_range(2));
            end
        end
        send_landmarks(p[0], p[1], p[2], p[3], p[4], p[5]);
    endtask

    initial begin
        logic [CB-1:0] r [6];
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.left_eye_x = 0; in_ch.left_eye_y = 0;
        in_ch.right_eye_x = 0; in_ch.right_eye_y = 0;
        in_ch.mouth_x = 0; in_ch.mouth_y = 0;
        quiet_phase = 0; hold_off = 0;
        directed_cnt = 0; random_cnt = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset references are all zero, so only the movement test acts
        send_landmarks(0, 0, 0, 0, 0, 0);
        send_landmarks(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_landmarks(0, 5, 7, 9, 11, 0);
        drain();

        write_refs(1000, 1000, 1200, 1000, 1100, 1200);
        write_reg(R_MOVE, 24000);
        write_reg(R_SLOPE, 3);
        // near, far, normal, near at a 1.2 linear scale, zero dx, left, right, up, down
        send_landmarks(980, 980, 1240, 980, 1110, 1240);
        send_landmarks(1020, 1020, 1170, 1020, 1095, 1170);
        send_landmarks(1000, 1000, 1200, 1000, 1100, 1200);
        send_landmarks(1000, 1000, 1240, 1000, 1120, 1240);
        send_landmarks(1000, 1300, 1250, 1000, 1150, 1200);
        send_landmarks(1150, 1010, 1350, 1010, 1250, 1210);
        send_landmarks(850, 990, 1050, 990, 950, 1190);
        send_landmarks(1010, 800, 1210, 800, 1110, 1000);
        send_landmarks(1010, 1200, 1210, 1200, 1110, 1400);
        send_landmarks(990, 1200, 1210, 1200, 1110, 1400);
        send_landmarks(CMAX, 0, 0, CMAX, CMAX, CMAX);
        drain();

        // degenerate reference: two coincident landmarks
        write_refs(500, 500, 500, 500, 900, 900);
        write_reg(R_MOVE, 0);
        write_reg(R_SLOPE, 0);
        send_landmarks(500, 500, 500, 500, 900, 900);
        send_landmarks(501, 502, 503, 504, 905, 906);
        send_landmarks(499, 600, 498, 700, 899, 800);
        drain();
        write_reg(R_MOVE, {MOVE_BITS{1'b1}});
        write_reg(R_SLOPE, {SLOPE_BITS{1'b1}});
        write_refs(0, 0, CMAX, 0, CMAX / 2, CMAX);
        send_landmarks(0, 0, CMAX, 0, CMAX / 2, CMAX);
        send_landmarks(CMAX / 4, CMAX / 4, CMAX * 3 / 4, CMAX / 4, CMAX / 2, CMAX * 3 / 4);
        send_landmarks(CMAX, CMAX, 0, CMAX, CMAX, 0);
        drain();
        directed_cnt = taken;

        // random phases with varied references and thresholds
        for (int phase = 0; phase < 8; phase++) begin
            for (int k = 0; k < 6; k++) r[k] = CB'($urandom_range(200, CMAX - 200));
            if (phase == 7) for (int k = 0; k < 6; k++) r[k] = CB'($urandom);
            write_refs(r[0], r[1], r[2], r[3], r[4], r[5]);
            case (phase % 4)
                0: write_reg(R_MOVE, CFG_DATA_BITS'($urandom_range(2000, 40000)));
                1: write_reg(R_MOVE, 0);
                2: write_reg(R_MOVE, CFG_DATA_BITS'($urandom_range(100, 5000)));
                default: write_reg(R_MOVE, CFG_DATA_BITS'($urandom));
            endcase
            write_reg(R_SLOPE, (phase == 3) ? CFG_DATA_BITS'($urandom)
                                            : CFG_DATA_BITS'($urandom_range(0, 6)));
            quiet_phase = (phase == 2);
            for (int n = 0; n < 100; n++) begin
                // long output hold-off while input keeps offering
                if (phase == 4 && n == 10) hold_off = 200;
                send_random(r);
                random_cnt++;
            end
            quiet_phase = 0;
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d directed and %0d random landmark sets, %0d postures checked,",
                 directed_cnt, random_cnt, delivered);
        $display("over eight reference and threshold settings including both extremes.");
        if (fail_count == 0 && pending == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
